// ----- design/brsd_pkg.sv -----
// ----------------------------------------------------------------------------
// brsd_pkg
// Shared widths, codes and types of the block RMS sound detector.
// ----------------------------------------------------------------------------
package brsd_pkg;

    localparam int SAMPLE_W          = 32;
    localparam int SQ_W              = 64;
    localparam int THR_W             = 63;
    localparam int RUN_W             = 10;
    localparam int MAX_BLOCK_SAMPLES = 256;
    localparam int CNT_W             = $clog2(MAX_BLOCK_SAMPLES + 1);
    localparam int PROD_W            = THR_W + CNT_W;
    localparam int CFG_IDX_W         = 2;

    localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOUND_BLOCKS  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_BLOCKS = 2'd2;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_SOUND   = 2'd1,
        EV_SILENCE = 2'd2
    } event_t;

    typedef struct packed {
        logic [SQ_W-1:0]  square_sum;
        logic [CNT_W-1:0] sample_count;
    } blk_t;

endpackage

// ----- design/brsd_acc.sv -----
// ----------------------------------------------------------------------------
// brsd_acc
// Input register, sample squaring and saturating block accumulation.
// Emits one beat with the block's sum and count for every closing sample.
// ----------------------------------------------------------------------------
module brsd_acc
    import brsd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [SAMPLE_W-1:0] sample,
    input  logic                last,
    output logic                blk_valid,
    input  logic                blk_stall,
    output blk_t                blk
);

    logic                s1_valid_reg;
    logic [SAMPLE_W-1:0] s1_sample_reg;
    logic                s1_last_reg;
    logic                s2_valid_reg;
    logic [SQ_W-1:0]     s2_sq_reg;
    logic                s2_last_reg;
    logic [SQ_W-1:0]     sum_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                s3_valid_reg;
    blk_t                s3_blk_reg;

    logic                s3_ready;
    logic                s2_go;
    logic                s2_ready;
    logic                s1_ready;
    logic [SAMPLE_W-1:0] mag;
    logic [SQ_W:0]       sum_wide;
    logic [SQ_W-1:0]     sum_next;
    logic [CNT_W-1:0]    cnt_next;

    assign s3_ready = !s3_valid_reg || !blk_stall;
    assign s2_go    = s2_valid_reg && (!s2_last_reg || s3_ready);
    assign s2_ready = !s2_valid_reg || s2_go;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    assign mag      = s1_sample_reg[SAMPLE_W-1] ? (~s1_sample_reg + 1'b1) : s1_sample_reg;
    assign sum_wide = {1'b0, sum_reg} + {1'b0, s2_sq_reg};
    assign sum_next = sum_wide[SQ_W] ? {SQ_W{1'b1}} : sum_wide[SQ_W-1:0];
    assign cnt_next = (cnt_reg < CNT_W'(MAX_BLOCK_SAMPLES)) ? cnt_reg + 1'b1 : cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            sum_reg      <= '0;
            cnt_reg      <= '0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s2_go)
            begin
                if (s2_last_reg)
                begin
                    sum_reg <= '0;
                    cnt_reg <= '0;
                end
                else
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                end
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_go && s2_last_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_sample_reg <= sample;
            s1_last_reg   <= last;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_sq_reg   <= SQ_W'(mag) * SQ_W'(mag);
            s2_last_reg <= s1_last_reg;
        end
        if (s3_ready && s2_go && s2_last_reg)
        begin
            s3_blk_reg.square_sum   <= sum_next;
            s3_blk_reg.sample_count <= cnt_next;
        end
    end

    assign blk_valid = s3_valid_reg;
    assign blk       = s3_blk_reg;

`ifndef SYNTH
    a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(MAX_BLOCK_SAMPLES))
        else $error("block sample count exceeds its limit");
    a_blk_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> s3_blk_reg.sample_count != '0)
        else $error("closed block carries no samples");
    a_acc_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_go && s2_last_reg) |=> (sum_reg == '0 && cnt_reg == '0))
        else $error("accumulator not cleared after block end");
`endif

endmodule

// ----- design/brsd_hyst.sv -----
// ----------------------------------------------------------------------------
// brsd_hyst
// Threshold product, loud decision, run counters with hysteresis and the
// result register.
// ----------------------------------------------------------------------------
module brsd_hyst
    import brsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             blk_valid,
    output logic             blk_stall,
    input  blk_t             blk,
    input  logic [THR_W-1:0] threshold,
    input  logic [RUN_W-1:0] sound_needed,
    input  logic [RUN_W-1:0] silence_needed,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [1:0]       event_res,
    output logic             silent,
    output logic             loud_block
);

    logic              s4_valid_reg;
    logic [SQ_W-1:0]   s4_sum_reg;
    logic [PROD_W-1:0] s4_prod_reg;
    logic [RUN_W-1:0]  loud_run_reg;
    logic [RUN_W-1:0]  loud_run_next;
    logic [RUN_W-1:0]  quiet_run_reg;
    logic [RUN_W-1:0]  quiet_run_next;
    logic              silent_reg;
    logic              silent_next;
    logic              out_valid_reg;
    event_t            event_reg;
    event_t            event_next;
    logic              loud_reg;

    logic              out_free;
    logic              out_go;
    logic              s4_ready;
    logic [THR_W-1:0]  thr_eff;
    logic [RUN_W-1:0]  need_sound;
    logic [RUN_W-1:0]  need_quiet;
    logic              loud;

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_go    = s4_valid_reg && out_free;
    assign s4_ready  = !s4_valid_reg || out_free;
    assign blk_stall = !s4_ready;

    assign thr_eff    = (threshold == '0) ? THR_W'(1) : threshold;
    assign need_sound = (sound_needed == '0) ? RUN_W'(1) : sound_needed;
    assign need_quiet = (silence_needed == '0) ? RUN_W'(1) : silence_needed;

    assign loud = (s4_prod_reg[PROD_W-1:SQ_W] == '0)
                  && (s4_sum_reg >= s4_prod_reg[SQ_W-1:0]);

    always_comb
    begin
        event_next  = EV_NONE;
        silent_next = silent_reg;
        if (loud)
        begin
            loud_run_next  = loud_run_reg + 1'b1;
            quiet_run_next = '0;
        end
        else
        begin
            loud_run_next  = '0;
            quiet_run_next = (quiet_run_reg < RUN_MAX) ? quiet_run_reg + 1'b1 : quiet_run_reg;
        end
        if (loud_run_next >= need_sound && silent_next)
        begin
            event_next    = EV_SOUND;
            loud_run_next = '0;
            silent_next   = 1'b0;
        end
        if (quiet_run_next >= need_quiet && !silent_next)
        begin
            event_next     = EV_SILENCE;
            quiet_run_next = '0;
            loud_run_next  = '0;
            silent_next    = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            loud_run_reg  <= '0;
            quiet_run_reg <= '0;
            silent_reg    <= 1'b1;
        end
        else
        begin
            if (s4_ready)
            begin
                s4_valid_reg <= blk_valid;
            end
            if (out_go)
            begin
                out_valid_reg <= 1'b1;
                loud_run_reg  <= loud_run_next;
                quiet_run_reg <= quiet_run_next;
                silent_reg    <= silent_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && blk_valid)
        begin
            s4_sum_reg  <= blk.square_sum;
            s4_prod_reg <= PROD_W'(thr_eff) * PROD_W'(blk.sample_count);
        end
        if (out_go)
        begin
            event_reg <= event_next;
            loud_reg  <= loud;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = event_reg;
    assign silent     = silent_reg;
    assign loud_block = loud_reg;

`ifndef SYNTH
    a_sound_clears_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_reg == EV_SOUND) |-> !silent_reg)
        else $error("sound start reported while still silent");
    a_silence_sets_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && event_reg == EV_SILENCE) |-> (silent_reg && !loud_reg))
        else $error("silence start reported on a loud block or while sounding");
    a_runs_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        (loud_run_reg == '0) || (quiet_run_reg == '0))
        else $error("loud and quiet runs both active");
    a_state_only_on_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(out_go) |-> $stable(silent_reg))
        else $error("detector state changed without a result beat");
`endif

endmodule

// ----- design/block_rms_sound_detector_top.sv -----
// A closing sample passes the input, square, block, product and result registers before its result beat is valid.
// Throughput: one sample beat per cycle while in_stall is low; at most one result beat per block.
// A pending result waits in the output register while further samples are taken.
// Reset clears the accumulator, run counters and pipeline, sets the state to silent
// and loads the threshold (1) and run lengths (3 and 10) reset values.
// ----------------------------------------------------------------------------
// block_rms_sound_detector_top
// Block RMS sound detector with loud and quiet run hysteresis and a plain
// register write port.
// ----------------------------------------------------------------------------
module block_rms_sound_detector_top
    import brsd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [THR_W-1:0]     cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [SAMPLE_W-1:0]  sample,
    input  logic                 last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [1:0]           event_res,
    output logic                 silent,
    output logic                 loud_block
);

    logic [THR_W-1:0] threshold_reg;
    logic [RUN_W-1:0] sound_needed_reg;
    logic [RUN_W-1:0] silence_needed_reg;

    logic blk_valid;
    logic blk_stall;
    blk_t blk;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg      <= THR_W'(1);
            sound_needed_reg   <= RUN_W'(3);
            silence_needed_reg <= RUN_W'(10);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD:      threshold_reg      <= cfg_wdata;
                CFG_SOUND_BLOCKS:   sound_needed_reg   <= cfg_wdata[RUN_W-1:0];
                CFG_SILENCE_BLOCKS: silence_needed_reg <= cfg_wdata[RUN_W-1:0];
                default:            ;
            endcase
        end
    end

    brsd_acc u_acc (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .sample    (sample),
        .last      (last),
        .blk_valid (blk_valid),
        .blk_stall (blk_stall),
        .blk       (blk)
    );

    brsd_hyst u_hyst (
        .clk            (clk),
        .rst_n          (rst_n),
        .blk_valid      (blk_valid),
        .blk_stall      (blk_stall),
        .blk            (blk),
        .threshold      (threshold_reg),
        .sound_needed   (sound_needed_reg),
        .silence_needed (silence_needed_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .event_res      (event_res),
        .silent         (silent),
        .loud_block     (loud_block)
    );

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the block RMS sound detector against a cycle-free predictor of the
// block sum, the loud test and the loud and quiet run hysteresis. Samples are
// sent in blocks closed by last, with random gaps and output stalls, and each
// result beat is compared field by field with the oldest predicted verdict.
// ----------------------------------------------------------------------------
import brsd_pkg::*;

typedef struct {
    event_t ev;
    logic   silent;
    logic   loud;
} verdict_t;

class rms_detect_scoreboard;
    logic [THR_W-1:0] threshold;
    logic [RUN_W-1:0] sound_need;
    logic [RUN_W-1:0] silence_need;
    logic [SQ_W-1:0]  sum_sq;
    logic [CNT_W-1:0] n_samples;
    logic [RUN_W-1:0] loud_run;
    logic [RUN_W-1:0] quiet_run;
    logic             is_silent;
    verdict_t         expected_verdicts[$];
    int               errors;

    function new();
        threshold    = THR_W'(1);
        sound_need   = RUN_W'(3);
        silence_need = RUN_W'(10);
        sum_sq       = '0;
        n_samples    = '0;
        loud_run     = '0;
        quiet_run    = '0;
        is_silent    = 1'b1;
        errors       = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [THR_W-1:0] val);
        case (idx)
            CFG_THRESHOLD:      threshold    = val;
            CFG_SOUND_BLOCKS:   sound_need   = val[RUN_W-1:0];
            CFG_SILENCE_BLOCKS: silence_need = val[RUN_W-1:0];
            default: ;
        endcase
    endfunction

    function void note_sample(logic [SAMPLE_W-1:0] s, logic lst);
        logic [SAMPLE_W:0] mag;
        logic [SQ_W-1:0]   sq;
        logic [SQ_W:0]     acc;
        logic [THR_W-1:0]  thr_eff;
        logic [71:0]       floor_val;
        logic [RUN_W-1:0]  need_snd;
        logic [RUN_W-1:0]  need_sil;
        logic              loud;
        verdict_t          v;
        mag = {1'b0, s};
        if (s[SAMPLE_W-1])
            mag = 33'h1_0000_0000 - mag;
        sq = {31'b0, mag} * {31'b0, mag};
        acc = {1'b0, sum_sq} + {1'b0, sq};
        sum_sq = acc[SQ_W] ? '1 : acc[SQ_W-1:0];
        if (n_samples < MAX_BLOCK_SAMPLES)
            n_samples = n_samples + 1'b1;
        if (!lst)
            return;
        thr_eff = (threshold == '0) ? 63'd1 : threshold;
        floor_val = {9'b0, thr_eff} * {63'b0, n_samples};
        loud = (floor_val[71:64] == '0) && (sum_sq >= floor_val[63:0]);
        if (loud)
        begin
            loud_run  = loud_run + 1'b1;
            quiet_run = '0;
        end
        else
        begin
            if (quiet_run != RUN_MAX)
                quiet_run = quiet_run + 1'b1;
            loud_run = '0;
        end
        need_snd = (sound_need == '0) ? 10'd1 : sound_need;
        need_sil = (silence_need == '0) ? 10'd1 : silence_need;
        v.ev = EV_NONE;
        if (loud_run >= need_snd && is_silent)
        begin
            v.ev      = EV_SOUND;
            loud_run  = '0;
            is_silent = 1'b0;
        end
        if (quiet_run >= need_sil && !is_silent)
        begin
            v.ev      = EV_SILENCE;
            quiet_run = '0;
            loud_run  = '0;
            is_silent = 1'b1;
        end
        sum_sq    = '0;
        n_samples = '0;
        v.silent  = is_silent;
        v.loud    = loud;
        expected_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic [1:0] ev, logic sil, logic loud);
        verdict_t v;
        if (expected_verdicts.size() == 0)
        begin
            $error("result beat with no verdict pending: event_res %0d silent %0d loud_block %0d",
                   ev, sil, loud);
            errors++;
            return;
        end
        v = expected_verdicts.pop_front();
        if (ev !== v.ev)
        begin
            $error("event_res mismatch: expected %0d, actual %0d", v.ev, ev);
            errors++;
        end
        if (sil !== v.silent)
        begin
            $error("silent mismatch: expected %0d, actual %0d", v.silent, sil);
            errors++;
        end
        if (loud !== v.loud)
        begin
            $error("loud_block mismatch: expected %0d, actual %0d", v.loud, loud);
            errors++;
        end
    endfunction
endclass

module tb_top;
    localparam int RESULT_LATENCY = 4;
    localparam int HOLD_CYCLES    = 150;
    localparam int LIMIT_CYCLES   = 200000;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [THR_W-1:0]     cfg_wdata;
    logic                 in_valid;
    logic                 in_stall;
    logic [SAMPLE_W-1:0]  sample;
    logic                 last;
    logic                 out_valid;
    logic                 out_stall;
    logic [1:0]           event_res;
    logic                 silent;
    logic                 loud_block;

    rms_detect_scoreboard board = new();

    int cycles     = 0;
    int tx_gap_pct = 30;
    int rx_busy_pct = 30;
    int stall_left = 0;
    bit hold_off_req = 1'b0;

    block_rms_sound_detector_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample     (sample),
        .last       (last),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .event_res  (event_res),
        .silent     (silent),
        .loud_block (loud_block)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("[block_rms_sound_detector_top] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            board.note_sample(sample, last);
        if (rst_n && out_valid && !out_stall)
            board.check_verdict(event_res, silent, loud_block);
    end

    // Receiver: random stall bursts, plus one long hold-off on request.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (hold_off_req)
        begin
            hold_off_req = 1'b0;
            stall_left   = HOLD_CYCLES - 1;
            out_stall   <= 1'b1;
        end
        else if (rst_n && $urandom_range(1, 100) <= rx_busy_pct)
        begin
            stall_left = $urandom_range(0, 3);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    task automatic idle_beats(input int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic push_beat(input logic [SAMPLE_W-1:0] s, input logic lst);
        if ($urandom_range(1, 100) <= tx_gap_pct)
            idle_beats($urandom_range(1, 4));
        @(negedge clk);
        in_valid <= 1'b1;
        sample   <= s;
        last     <= lst;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (board.expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.set_register(idx, val);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [THR_W-1:0] thr, input logic [RUN_W-1:0] snd,
                             input logic [RUN_W-1:0] sil);
        drain();
        write_reg(CFG_THRESHOLD, thr);
        write_reg(CFG_SOUND_BLOCKS, {53'b0, snd});
        write_reg(CFG_SILENCE_BLOCKS, {53'b0, sil});
    endtask

    function automatic int half_bits();
        logic [THR_W-1:0] thr_eff;
        thr_eff = (board.threshold == '0) ? 63'd1 : board.threshold;
        return ($clog2(thr_eff) + 1) / 2;
    endfunction

    function automatic logic [SAMPLE_W-1:0] make_sample(input bit loud_mode, input int h);
        logic [32:0] mag;
        int          k;
        if ($urandom_range(0, 6) == 0)
            return $urandom;
        if (loud_mode)
        begin
            if (h >= 31)
                mag = 33'h0_8000_0000;
            else
                mag = (33'd1 << h) | ({1'b0, $urandom} & ((33'd1 << h) - 1));
        end
        else
        begin
            k = (h > 1) ? h - 1 : 0;
            mag = {1'b0, $urandom} & ((33'd1 << k) - 1);
        end
        if ($urandom_range(0, 1))
            return -mag[31:0];
        return mag[31:0];
    endfunction

    task automatic run_blocks(input int beats_target, input bit with_long);
        int sent;
        int len;
        int h;
        bit loud_mode;
        sent      = 0;
        h         = half_bits();
        loud_mode = 1'($urandom_range(0, 1));
        while (sent < beats_target)
        begin
            if ($urandom_range(0, 3) == 0)
                loud_mode = !loud_mode;
            len = (with_long && sent == 0) ? 300 : $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                push_beat(make_sample(loud_mode, h), i == len - 1);
            sent += len;
        end
    endtask

    initial
    begin
        logic [THR_W-1:0] thr;
        logic [RUN_W-1:0] snd;
        logic [RUN_W-1:0] sil;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_THRESHOLD;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        sample    = '0;
        last      = 1'b0;
        out_stall = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset settings: quiet zero block, loud extremes, then sound starts.
        push_beat(32'h0000_0000, 1'b1);
        push_beat(32'h7FFF_FFFF, 1'b1);
        push_beat(32'h8000_0000, 1'b1);
        push_beat(32'h0000_0001, 1'b1);
        push_beat(32'hFFFF_FFFF, 1'b0);
        push_beat(32'h0000_0000, 1'b1);
        // Five full-scale negative samples push the block sum into saturation.
        repeat (4) push_beat(32'h8000_0000, 1'b0);
        push_beat(32'h8000_0000, 1'b1);

        // Zero threshold and zero run lengths all act as one.
        configure('0, '0, '0);
        push_beat(32'h0000_0000, 1'b1);
        push_beat(32'h0000_0005, 1'b1);
        push_beat(32'h0000_0000, 1'b1);

        // Threshold of 1 << 62: one full-scale sample is loud, four overflow the product.
        configure(63'd1 << 62, 10'd1, 10'd1);
        push_beat(32'h8000_0000, 1'b1);
        repeat (3) push_beat(32'h8000_0000, 1'b0);
        push_beat(32'h8000_0000, 1'b1);
        push_beat(32'h8000_0000, 1'b0);
        push_beat(32'h8000_0000, 1'b1);

        for (int p = 0; p < 10; p++)
        begin
            case (p % 6)
                0:       thr = '0;
                1:       thr = 63'd1;
                2:       thr = 63'd1 << 62;
                3:       thr = THR_W'($urandom_range(1, 65536));
                default: thr = {31'b0, $urandom} << $urandom_range(0, 30);
            endcase
            case (p % 5)
                0:       snd = '0;
                1:       snd = 10'd1;
                2:       snd = RUN_MAX;
                default: snd = RUN_W'($urandom_range(1, 4));
            endcase
            case (p % 4)
                0:       sil = RUN_MAX;
                1:       sil = '0;
                default: sil = RUN_W'($urandom_range(1, 6));
            endcase
            tx_gap_pct  = (p % 3 == 0) ? 0 : 30;
            rx_busy_pct = (p % 4 == 3) ? 0 : 30;
            configure(thr, snd, sil);
            if (p == 4)
            begin
                // The receiver holds off while one-sample blocks keep coming.
                tx_gap_pct   = 0;
                hold_off_req = 1'b1;
                repeat (40)
                    push_beat(make_sample(1'($urandom_range(0, 1)), half_bits()), 1'b1);
                tx_gap_pct = 30;
            end
            run_blocks(70, p == 1 || p == 2);
        end

        // Closing stretch with no idling on either side.
        configure(63'd400, 10'd2, 10'd3);
        tx_gap_pct  = 0;
        rx_busy_pct = 0;
        run_blocks(100, 1'b0);

        drain();
        if (board.errors == 0)
            $display("[block_rms_sound_detector_top] OK");
        else
            $display("[block_rms_sound_detector_top] ERROR");
        $finish;
    end
endmodule
